>>> hw/rtl/pptrk_pkg.sv
// Shared types and constants for the pointer position tracker.
// Holds the input and result word layouts and the configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pptrk_pkg;

	localparam int PPT_REF_WIDTH  = 640;
	localparam int PPT_REF_HEIGHT = 480;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_MODE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_LOGICAL_MIN   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_X_LOGICAL_MAX   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LOGICAL_MIN   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LOGICAL_MAX   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_INRANGE_PRESENT = 4'd7;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic [4:0]         button_bits;
		logic               tip_switch;
		logic               in_range;
		logic signed [7:0]  wheel_delta;
		logic signed [7:0]  pan_delta;
	} item_t;

	typedef struct packed {
		logic [7:0] contact_flags;
		logic [7:0] x_window_low;
		logic [7:0] x_window_mid;
		logic [7:0] x_window_high;
		logic [7:0] y_window_low;
		logic [7:0] y_window_high;
		logic [7:0] wheel_total;
		logic [7:0] pan_total;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/pointer_position_tracker_core.sv
// Top level of the pointer position tracker: sequencer, shared serial divider and state.
// Depends on pptrk_pkg for the word types and register indexes.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted word yields one contact record. Every scaling runs through one shared restoring
// divider that produces one quotient bit per cycle: 42 steps for a logical-range scaling, 20 steps
// for the others, after a prepare and a load state per division. A logical-range scaling with an
// empty or reversed range or a value below the minimum skips the divider. A new word is taken
// while the previous record still waits in the output register.
module pointer_position_tracker_core
	import pptrk_pkg::*;
#(
	parameter int REF_WIDTH  = PPT_REF_WIDTH,
	parameter int REF_HEIGHT = PPT_REF_HEIGHT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_t                item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	localparam int RX_W    = $clog2(REF_WIDTH);
	localparam int RY_W    = $clog2(REF_HEIGHT);
	localparam int NUM_W   = 42;
	localparam int SHORT_W = 20;
	localparam int DEN_W   = 32;
	localparam int CNT_W   = 6;

	typedef enum logic [2:0] {S_IDLE, S_PREP, S_LOAD, S_DIV, S_POST, S_OUT} state_t;

	state_t state_q;
	item_t it_q;
	logic [1:0] job_q;

	logic relative_q, inrange_q;
	logic [9:0] cw_reg_q, ch_reg_q;
	logic signed [31:0] xmin_q, xmax_q, ymin_q, ymax_q;

	logic [RX_W-1:0] ref_x_q;
	logic [RY_W-1:0] ref_y_q;
	logic signed [1:0] rem_x_q, rem_y_q;
	logic [9:0] cpx_q, cpy_q;
	logic [7:0] wheel_q, pan_q;

	logic [31:0] diff_q, span_q;
	logic bad_span_q, neg_q;

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [9:0] quo_q;
	logic ovf_q;
	logic [CNT_W-1:0] cnt_q;

	logic [9:0] cw, ch, cw_m1, ch_m1;
	logic signed [32:0] span_c, diff_c;
	logic [31:0] mul_a;
	logic [9:0] mul_b;
	logic [NUM_W-1:0] prod;
	logic short_job, skip_div;
	logic [DEN_W:0] shifted;
	logic [DEN_W+1:0] trial;
	logic qbit;
	logic [9:0] qres;
	logic signed [16:0] step_x, step_y;
	logic signed [1:0] nrem_x, nrem_y;
	logic signed [17:0] sum_rx, sum_ry;
	logic [9:0] cx, cy;
	result_t res_c;

	function automatic logic signed [16:0] half_step(input logic signed [1:0] r,
			input logic [15:0] d);
		logic signed [16:0] s;
		s = 17'(r) + 17'($signed(d));
		return (s + $signed({16'd0, s[16]})) >>> 1;
	endfunction

	function automatic logic signed [1:0] half_rem(input logic signed [1:0] r,
			input logic [15:0] d);
		logic signed [16:0] s;
		s = 17'(r) + 17'($signed(d));
		return s[0] ? (s[16] ? -2'sd1 : 2'sd1) : 2'sd0;
	endfunction

	function automatic logic [9:0] min10(input logic [9:0] a, input logic [9:0] b);
		return (a < b) ? a : b;
	endfunction

	assign cw    = (cw_reg_q == 10'd0) ? 10'd1 : cw_reg_q;
	assign ch    = (ch_reg_q == 10'd0) ? 10'd1 : ch_reg_q;
	assign cw_m1 = cw - 10'd1;
	assign ch_m1 = ch - 10'd1;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		if (job_q[0]) begin
			span_c = 33'(ymax_q) - 33'(ymin_q);
			diff_c = 33'(it_q.y_value) - 33'(ymin_q);
		end else begin
			span_c = 33'(xmax_q) - 33'(xmin_q);
			diff_c = 33'(it_q.x_value) - 33'(xmin_q);
		end
	end

	assign step_x = half_step(rem_x_q, it_q.x_value[15:0]);
	assign step_y = half_step(rem_y_q, it_q.y_value[15:0]);
	assign nrem_x = half_rem(rem_x_q, it_q.x_value[15:0]);
	assign nrem_y = half_rem(rem_y_q, it_q.y_value[15:0]);
	assign sum_rx = 18'($signed({1'b0, ref_x_q})) + 18'(step_x);
	assign sum_ry = 18'($signed({1'b0, ref_y_q})) + 18'(step_y);

	always_comb begin
		short_job = 1'b1;
		skip_div  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		if (relative_q) begin
			mul_a = job_q[0] ? 32'(ref_y_q) : 32'(ref_x_q);
			mul_b = cw;
		end else if (!job_q[1]) begin
			short_job = 1'b0;
			skip_div  = bad_span_q || neg_q;
			mul_a     = diff_q;
			mul_b     = job_q[0] ? ch_m1 : cw_m1;
		end else begin
			mul_a = job_q[0] ? 32'(cpy_q) : 32'(cpx_q);
			mul_b = 10'(REF_WIDTH);
		end
	end

	assign prod = NUM_W'(mul_a) * NUM_W'(mul_b);

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign qbit    = !trial[DEN_W+1];
	assign qres    = ovf_q ? 10'h3FF : quo_q;

	assign cx = min10(cpx_q, 10'd764);
	assign cy = min10(cpy_q, 10'd509);

	always_comb begin
		res_c.contact_flags = {it_q.in_range, 2'b00, it_q.button_bits};
		if (relative_q || inrange_q) begin
			res_c.contact_flags[7] = relative_q ? 1'b1 : it_q.in_range;
		end else begin
			res_c.contact_flags[7] = 1'b0;
		end
		res_c.contact_flags[0] = it_q.button_bits[0] | it_q.tip_switch;
		res_c.x_window_low  = (cx <= 10'd254) ? 8'(cx + 10'd1) : 8'd0;
		res_c.x_window_mid  = (cx > 10'd254 && cx <= 10'd509) ? 8'(cx - 10'd254) : 8'd0;
		res_c.x_window_high = (cx > 10'd509) ? 8'(cx - 10'd509) : 8'd0;
		res_c.y_window_low  = (cy <= 10'd254) ? 8'(cy + 10'd1) : 8'd0;
		res_c.y_window_high = (cy > 10'd254) ? 8'(cy - 10'd254) : 8'd0;
		res_c.wheel_total   = wheel_q;
		res_c.pan_total     = pan_q;
		if (it_q.cmd) begin
			res_c.contact_flags = 8'd0;
			res_c.x_window_low  = 8'd1;
			res_c.x_window_mid  = 8'd0;
			res_c.x_window_high = 8'd0;
			res_c.y_window_low  = 8'd1;
			res_c.y_window_high = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relative_q <= 1'b0;
			inrange_q  <= 1'b0;
			cw_reg_q   <= 10'd320;
			ch_reg_q   <= 10'd240;
			xmin_q     <= '0;
			xmax_q     <= '0;
			ymin_q     <= '0;
			ymax_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RELATIVE_MODE:   relative_q <= cfg_data[0];
				CFG_CANVAS_WIDTH:    cw_reg_q   <= cfg_data[9:0];
				CFG_CANVAS_HEIGHT:   ch_reg_q   <= cfg_data[9:0];
				CFG_X_LOGICAL_MIN:   xmin_q     <= $signed(cfg_data);
				CFG_X_LOGICAL_MAX:   xmax_q     <= $signed(cfg_data);
				CFG_Y_LOGICAL_MIN:   ymin_q     <= $signed(cfg_data);
				CFG_Y_LOGICAL_MAX:   ymax_q     <= $signed(cfg_data);
				CFG_INRANGE_PRESENT: inrange_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			job_q        <= '0;
			ref_x_q      <= '0;
			ref_y_q      <= '0;
			rem_x_q      <= '0;
			rem_y_q      <= '0;
			cpx_q        <= '0;
			cpy_q        <= '0;
			wheel_q      <= '0;
			pan_q        <= '0;
			result_valid <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (result_valid && !result_stall && state_q != S_OUT) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						it_q  <= item;
						job_q <= '0;
						if (item.cmd) begin
							state_q <= S_OUT;
						end else begin
							wheel_q <= wheel_q + item.wheel_delta;
							pan_q   <= pan_q + item.pan_delta;
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					diff_q     <= diff_c[31:0];
					neg_q      <= diff_c[32];
					span_q     <= span_c[31:0];
					bad_span_q <= span_c[32] || (span_c == '0);
					if (relative_q && job_q == 2'd0) begin
						rem_x_q <= nrem_x;
						rem_y_q <= nrem_y;
						if (sum_rx[17]) begin
							ref_x_q <= '0;
						end else if (sum_rx > 18'(REF_WIDTH - 1)) begin
							ref_x_q <= RX_W'(REF_WIDTH - 1);
						end else begin
							ref_x_q <= sum_rx[RX_W-1:0];
						end
						if (sum_ry[17]) begin
							ref_y_q <= '0;
						end else if (sum_ry > 18'(REF_HEIGHT - 1)) begin
							ref_y_q <= RY_W'(REF_HEIGHT - 1);
						end else begin
							ref_y_q <= sum_ry[RY_W-1:0];
						end
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
					if (short_job) begin
						num_q <= prod << (NUM_W - SHORT_W);
						cnt_q <= CNT_W'(SHORT_W);
					end else begin
						num_q <= prod;
						cnt_q <= CNT_W'(NUM_W);
					end
					if (relative_q) begin
						den_q <= DEN_W'(REF_WIDTH);
					end else if (!job_q[1]) begin
						den_q <= span_q;
					end else begin
						den_q <= DEN_W'(cw);
					end
					state_q <= skip_div ? S_POST : S_DIV;
				end
				S_DIV: begin
					num_q <= num_q << 1;
					rem_q <= qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
					quo_q <= {quo_q[8:0], qbit};
					ovf_q <= ovf_q | quo_q[9];
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					state_q <= S_PREP;
					job_q   <= job_q + 2'd1;
					if (relative_q) begin
						if (job_q[0]) begin
							cpy_q   <= min10(qres, ch_m1);
							state_q <= S_OUT;
						end else begin
							cpx_q <= min10(qres, cw_m1);
						end
					end else begin
						case (job_q)
							2'd0: cpx_q <= bad_span_q ? min10(cpx_q, cw_m1) :
								(neg_q ? 10'd0 : min10(qres, cw_m1));
							2'd1: cpy_q <= bad_span_q ? min10(cpy_q, ch_m1) :
								(neg_q ? 10'd0 : min10(qres, ch_m1));
							2'd2: begin
								ref_x_q <= RX_W'(min10(qres, 10'(REF_WIDTH - 1)));
								rem_x_q <= '0;
							end
							default: begin
								ref_y_q <= RY_W'(min10(qres, 10'(REF_HEIGHT - 1)));
								rem_y_q <= '0;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_OUT: begin
					if (!result_valid || !result_stall) begin
						result       <= res_c;
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> dv/tb_pointer_position_tracker_core.sv
// Self-checking testbench for pointer_position_tracker_core: directed and random words in both
// modes with randomized idling, predicted by a scoreboard class and compared field by field.
// Depends on pptrk_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_pointer_position_tracker_core;
	import pptrk_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	class contact_scoreboard;
		bit rel_mode, inrange_en;
		int canvas_w, canvas_h;
		longint x_min, x_max, y_min, y_max;
		int ref_x, ref_y, rem_x, rem_y, pos_x, pos_y;
		logic [7:0] wheel_sum, pan_sum;
		result_t pending_records[$];
		int errors;

		function new();
			rel_mode = 0; inrange_en = 0; canvas_w = 320; canvas_h = 240;
			x_min = 0; x_max = 0; y_min = 0; y_max = 0;
			ref_x = 0; ref_y = 0; rem_x = 0; rem_y = 0; pos_x = 0; pos_y = 0;
			wheel_sum = 0; pan_sum = 0; errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
			case (idx)
				CFG_RELATIVE_MODE:   rel_mode = v[0];
				CFG_CANVAS_WIDTH:    canvas_w = v[9:0];
				CFG_CANVAS_HEIGHT:   canvas_h = v[9:0];
				CFG_X_LOGICAL_MIN:   x_min = longint'($signed(v));
				CFG_X_LOGICAL_MAX:   x_max = longint'($signed(v));
				CFG_Y_LOGICAL_MIN:   y_min = longint'($signed(v));
				CFG_Y_LOGICAL_MAX:   y_max = longint'($signed(v));
				CFG_INRANGE_PRESENT: inrange_en = v[0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void move_axis(inout int rem, inout int pos, input logic signed [15:0] d,
			input int lim);
			int sum, half;
			sum = rem + int'(d);
			half = sum / 2;
			rem = sum - half * 2;
			pos = int'(clip(pos + half, 0, lim));
		endfunction

		function void scale_axis(inout int pos, input logic signed [31:0] v, input longint lo,
			input longint hi, input int size);
			longint span;
			span = hi - lo;
			if (span > 0)
				pos = int'(clip(((longint'(v) - lo) * longint'(size - 1)) / span, 0, 1023));
		endfunction

		function result_t encode(logic [7:0] flags, int x, int y);
			result_t r;
			int cx, cy;
			cx = int'(clip(x, 0, 764));
			cy = int'(clip(y, 0, 509));
			r.contact_flags = flags;
			r.x_window_low  = cx <= 254 ? 8'(cx + 1) : 8'd0;
			r.x_window_mid  = (cx > 254 && cx <= 509) ? 8'(cx - 254) : 8'd0;
			r.x_window_high = cx > 509 ? 8'(cx - 509) : 8'd0;
			r.y_window_low  = cy <= 254 ? 8'(cy + 1) : 8'd0;
			r.y_window_high = cy > 254 ? 8'(cy - 254) : 8'd0;
			r.wheel_total   = wheel_sum;
			r.pan_total     = pan_sum;
			return r;
		endfunction

		function void note_word(item_t w);
			int cw, ch;
			logic [7:0] flags;
			bit hover;
			cw = canvas_w == 0 ? 1 : canvas_w;
			ch = canvas_h == 0 ? 1 : canvas_h;
			if (w.cmd) begin
				pending_records.push_back(encode(8'd0, 0, 0));
				return;
			end
			if (rel_mode) begin
				move_axis(rem_x, ref_x, w.x_value[15:0], PPT_REF_WIDTH - 1);
				move_axis(rem_y, ref_y, w.y_value[15:0], PPT_REF_HEIGHT - 1);
				pos_x = ref_x * cw / PPT_REF_WIDTH;
				pos_y = ref_y * cw / PPT_REF_WIDTH;
			end else begin
				scale_axis(pos_x, w.x_value, x_min, x_max, cw);
				scale_axis(pos_y, w.y_value, y_min, y_max, ch);
			end
			pos_x = int'(clip(pos_x, 0, cw - 1));
			pos_y = int'(clip(pos_y, 0, ch - 1));
			if (!rel_mode) begin
				ref_x = int'(clip(longint'(pos_x) * PPT_REF_WIDTH / cw, 0, PPT_REF_WIDTH - 1));
				ref_y = int'(clip(longint'(pos_y) * PPT_REF_WIDTH / cw, 0, PPT_REF_HEIGHT - 1));
				rem_x = 0;
				rem_y = 0;
			end
			flags = {3'b000, w.button_bits};
			if (w.tip_switch)
				flags[0] = 1'b1;
			hover = rel_mode;
			if (!rel_mode && inrange_en)
				hover = w.in_range;
			if (hover)
				flags[7] = 1'b1;
			wheel_sum = wheel_sum + w.wheel_delta;
			pan_sum = pan_sum + w.pan_delta;
			pending_records.push_back(encode(flags, pos_x, pos_y));
		endfunction

		function void report(string what, logic [7:0] got, logic [7:0] want);
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
			errors++;
		endfunction

		function void check_record(result_t got);
			result_t want;
			if (pending_records.size() == 0) begin
				report("unexpected record, contact_flags", got.contact_flags, 8'd0);
				return;
			end
			want = pending_records.pop_front();
			if (got.contact_flags != want.contact_flags)
				report("contact_flags", got.contact_flags, want.contact_flags);
			if (got.x_window_low != want.x_window_low)
				report("x_window_low", got.x_window_low, want.x_window_low);
			if (got.x_window_mid != want.x_window_mid)
				report("x_window_mid", got.x_window_mid, want.x_window_mid);
			if (got.x_window_high != want.x_window_high)
				report("x_window_high", got.x_window_high, want.x_window_high);
			if (got.y_window_low != want.y_window_low)
				report("y_window_low", got.y_window_low, want.y_window_low);
			if (got.y_window_high != want.y_window_high)
				report("y_window_high", got.y_window_high, want.y_window_high);
			if (got.wheel_total != want.wheel_total)
				report("wheel_total", got.wheel_total, want.wheel_total);
			if (got.pan_total != want.pan_total)
				report("pan_total", got.pan_total, want.pan_total);
		endfunction
	endclass

	logic clk, arst_n;
	logic item_valid, item_stall;
	item_t item;
	logic result_valid, result_stall;
	result_t result;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	int send_idle_pct, recv_idle_pct;
	contact_scoreboard board;

	pointer_position_tracker_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL pointer_position_tracker_core");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_record(result);
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_word(item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		board.note_word(w);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (board.pending_records.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, v);
	endtask

	task automatic set_all(bit rel, int cw, int ch, longint xl, longint xh, longint yl,
		longint yh, bit inr);
		drain();
		set_reg(CFG_RELATIVE_MODE, 32'(rel));
		set_reg(CFG_CANVAS_WIDTH, 32'(cw));
		set_reg(CFG_CANVAS_HEIGHT, 32'(ch));
		set_reg(CFG_X_LOGICAL_MIN, 32'(xl));
		set_reg(CFG_X_LOGICAL_MAX, 32'(xh));
		set_reg(CFG_Y_LOGICAL_MIN, 32'(yl));
		set_reg(CFG_Y_LOGICAL_MAX, 32'(yh));
		set_reg(CFG_INRANGE_PRESENT, 32'(inr));
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t make_word(bit rel_cmd, longint xv, longint yv);
		item_t w;
		w.cmd = rel_cmd;
		w.x_value = 32'(xv);
		w.y_value = 32'(yv);
		w.button_bits = 5'($urandom_range(31));
		w.tip_switch = 1'($urandom_range(1));
		w.in_range = 1'($urandom_range(1));
		w.wheel_delta = 8'($urandom);
		w.pan_delta = 8'($urandom);
		return w;
	endfunction

	function automatic longint pick_in(longint lo, longint hi);
		longint span;
		span = hi - lo;
		if (span <= 0 || $urandom_range(9) == 0)
			return longint'($signed($urandom));
		return lo - span / 8 + longint'({$urandom, $urandom} % (span + span / 4 + 1));
	endfunction

	function automatic longint rand_delta();
		if ($urandom_range(7) == 0)
			return longint'($urandom);
		return longint'({$urandom_range(65535), 16'h0}) + longint'(16'($urandom_range(80) - 40));
	endfunction

	function automatic int rand_size();
		case ($urandom_range(5))
			0: return 1;
			1: return 1023;
			default: return $urandom_range(2, 1022);
		endcase
	endfunction

	function automatic longint rand_lo();
		return $urandom_range(3) == 0 ? longint'($signed($urandom))
			: longint'($urandom_range(4000)) - 2000;
	endfunction

	function automatic longint clip_hi(longint v);
		return v > 64'sd2147483647 ? 64'sd2147483647 : v;
	endfunction

	function automatic longint rand_hi(longint lo);
		case ($urandom_range(9))
			0: return lo;
			1: return lo - longint'($urandom_range(50));
			2: return longint'(32'sh7FFFFFFF);
			default: return clip_hi(lo + longint'($urandom_range(5000)));
		endcase
	endfunction

	initial begin
		item_t w;
		bit rel;
		longint xl, xh, yl, yh;
		board = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration has empty logical ranges, so the position holds.
		send_word(make_word(1'b0, 12345, -5));
		send_word(make_word(1'b1, 0, 0));

		set_all(1'b0, 1023, 1023, -64'sd2147483648, 64'sd2147483647,
			-64'sd2147483648, 64'sd2147483647, 1'b1);
		send_word(make_word(1'b0, 64'sd2147483647, 64'sd2147483647));
		send_word(make_word(1'b0, -64'sd2147483648, -64'sd2147483648));
		send_word(make_word(1'b0, 0, 0));
		w = make_word(1'b0, 64'sd1073741824, 64'sd536870912);
		w.button_bits = 5'h1F; w.tip_switch = 1'b1; w.in_range = 1'b1;
		w.wheel_delta = 8'sh7F; w.pan_delta = -8'sd128;
		send_word(w);
		w.button_bits = 5'h00; w.tip_switch = 1'b0; w.in_range = 1'b0;
		w.wheel_delta = -8'sd128; w.pan_delta = 8'sh7F;
		send_word(w);
		send_word(make_word(1'b1, 64'sd2147483647, 64'sd2147483647));

		// Low height with wide width leaves the resynced reference Y far below its limit.
		set_all(1'b0, 1000, 20, 0, 100, 0, 100, 1'b0);
		send_word(make_word(1'b0, 100, 100));
		set_all(1'b1, 640, 480, 0, 100, 0, 100, 1'b0);
		send_word(make_word(1'b0, 32767, 32767));
		send_word(make_word(1'b0, 32767, 32767));
		send_word(make_word(1'b0, 64'hFFFF8000, 64'h00018000));
		send_word(make_word(1'b0, 1, -1));
		send_word(make_word(1'b0, 1, -1));
		send_word(make_word(1'b0, 64'h7FFF0003, 64'h12340003));
		set_all(1'b1, 1023, 1, 0, 0, 0, 0, 1'b1);
		send_word(make_word(1'b0, 32767, 32767));
		set_all(1'b0, 0, 0, -10, 10, -10, 10, 1'b0);
		send_word(make_word(1'b0, 10, 10));
		send_word(make_word(1'b0, -10, 5));

		for (int blk = 0; blk < 11; blk++) begin
			rel = $urandom_range(2) == 0;
			xl = rand_lo();
			yl = rand_lo();
			xh = rand_hi(xl);
			yh = rand_hi(yl);
			set_all(rel, rand_size(), rand_size(), xl, xh, yl, yh, 1'($urandom_range(1)));
			send_idle_pct = blk < 4 ? 28 : (blk < 8 ? 58 : 0);
			recv_idle_pct = blk < 4 ? 58 : (blk < 8 ? 28 : 0);
			for (int n = 0; n < 50; n++) begin
				if (n == 25 && blk % 3 == 0) begin
					item_valid <= 1'b0;
					while (board.pending_records.size() != 0)
						@(posedge clk);
				end
				if (rel)
					w = make_word($urandom_range(19) == 0, rand_delta(), rand_delta());
				else
					w = make_word($urandom_range(19) == 0, pick_in(xl, xh), pick_in(yl, yh));
				send_word(w);
			end
		end

		item_valid <= 1'b0;
		while (board.pending_records.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (board.errors == 0)
			$display("PASS pointer_position_tracker_core");
		else
			$display("FAIL pointer_position_tracker_core");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/pptrk_pkg.sv
hw/rtl/pointer_position_tracker_core.sv
dv/tb_pointer_position_tracker_core.sv
